FILE: design/cdlp_pkg.sv
`default_nettype none
package cdlp_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NODIGITS = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [63:0] MAX_POS_32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAX_POS_64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // register word index, taken from paddr[2]
  localparam logic REG_WIDTH_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       empty_marker;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

FILE: design/checked_decimal_literal_parser_unit.sv
// input words are registered in cdlp_in_stage, result words in cdlp_out_stage
// throughput: one character word per cycle, but a word ending a literal waits
//   for output room; the accumulator's multiply-by-ten, add and limit compare
//   are combinational; a result is held in the output register until taken
// reset: synchronous active-low rst_n clears valids, parse state and width_mode
`default_nettype none
module checked_decimal_literal_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // character
  input  wire logic        in_tlast,   // last
  input  wire logic        in_tuser,   // empty_marker
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // value
  output logic [2:0]       out_tuser,  // status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cdlp_pkg::item_t   item;
  cdlp_pkg::result_t result;
  logic              item_valid;
  logic              advance;
  logic              ends;
  logic              out_free;
  logic              width_mode;

  // a word that ends a literal waits for room in the output register
  assign advance = item_valid && (!ends || out_free);

  cdlp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .width_mode  (width_mode)
  );

  cdlp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  cdlp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .fire       (advance),
    .width_mode (width_mode),
    .ends       (ends),
    .result     (result)
  );

  cdlp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && ends),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: design/cdlp_cfg_regs.sv
`default_nettype none
module cdlp_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output logic             width_mode
);

  logic width_mode_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= 1'b0;
    end else if (wr_en && (cfg_paddr[2] == cdlp_pkg::REG_WIDTH_MODE)) begin
      width_mode_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == cdlp_pkg::REG_WIDTH_MODE) begin
      cfg_prdata = {31'd0, width_mode_r};
    end
  end

  assign width_mode = width_mode_r;

endmodule
`default_nettype wire

FILE: design/cdlp_in_stage.sv
`default_nettype none
module cdlp_in_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // character
  input  wire logic        in_tlast,  // last
  input  wire logic        in_tuser,  // empty_marker
  input  wire logic        advance,
  output cdlp_pkg::item_t  item,
  output logic             item_valid
);

  cdlp_pkg::item_t item_r;
  logic            valid_r;
  logic            valid_nxt;
  logic            load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.character    <= in_tdata;
      item_r.last         <= in_tlast;
      item_r.empty_marker <= in_tuser;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule
`default_nettype wire

FILE: design/cdlp_core.sv
`default_nettype none
module cdlp_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cdlp_pkg::item_t item,
  input  wire logic          fire,
  input  wire logic          width_mode,
  output logic               ends,
  output cdlp_pkg::result_t  result
);

  logic [63:0]       mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic              first_r, first_nxt;
  logic              dig_r, dig_nxt;
  cdlp_pkg::status_t err_r, err_nxt;

  logic [7:0]  c;
  logic        is_digit;
  logic [63:0] limit;
  logic [67:0] prod;
  logic        ovf;

  assign c        = item.character;
  assign is_digit = (c >= cdlp_pkg::CHAR_ZERO) && (c <= cdlp_pkg::CHAR_NINE);
  assign limit    = (width_mode ? cdlp_pkg::MAX_POS_64 : cdlp_pkg::MAX_POS_32)
                    + {63'd0, neg_r};
  // mag*10 + digit as shifts and adds; the digit is the low nibble of its code
  assign prod     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {64'd0, c[3:0]};
  assign ovf      = prod > {4'd0, limit};
  assign ends     = item.empty_marker || item.last;

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    dig_nxt   = dig_r;
    err_nxt   = err_r;
    if (!item.empty_marker && (err_r == cdlp_pkg::ST_OK)) begin
      if (!first_r && ((c == cdlp_pkg::CHAR_PLUS) || (c == cdlp_pkg::CHAR_MINUS))) begin
        neg_nxt   = (c == cdlp_pkg::CHAR_MINUS);
        first_nxt = 1'b1;
      end else begin
        first_nxt = 1'b1;
        if (is_digit) begin
          if (ovf) begin
            err_nxt = cdlp_pkg::ST_OVERFLOW;
          end else begin
            mag_nxt = prod[63:0];
            dig_nxt = 1'b1;
          end
        end else begin
          err_nxt = cdlp_pkg::ST_BADCHAR;
        end
      end
    end
  end

  always_comb begin
    result.value  = 64'd0;
    result.status = cdlp_pkg::ST_OK;
    if (!first_nxt) begin
      result.status = cdlp_pkg::ST_EMPTY;
    end else if (err_nxt != cdlp_pkg::ST_OK) begin
      result.status = err_nxt;
    end else if (!dig_nxt) begin
      result.status = cdlp_pkg::ST_NODIGITS;
    end else begin
      result.value = neg_nxt ? (64'd0 - mag_nxt) : mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r   <= 64'd0;
      neg_r   <= 1'b0;
      first_r <= 1'b0;
      dig_r   <= 1'b0;
      err_r   <= cdlp_pkg::ST_OK;
    end else if (fire) begin
      if (ends) begin
        mag_r   <= 64'd0;
        neg_r   <= 1'b0;
        first_r <= 1'b0;
        dig_r   <= 1'b0;
        err_r   <= cdlp_pkg::ST_OK;
      end else begin
        mag_r   <= mag_nxt;
        neg_r   <= neg_nxt;
        first_r <= first_nxt;
        dig_r   <= dig_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/cdlp_out_stage.sv
`default_nettype none
module cdlp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire cdlp_pkg::result_t result,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,  // value
  output logic [2:0]             out_tuser   // status
);

  cdlp_pkg::result_t res_r;
  logic              valid_r;
  logic              valid_nxt;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.value;
  assign out_tuser  = res_r.status;

endmodule
`default_nettype wire

FILE: design/cdlp_checker.sv
`default_nettype none
module cdlp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        cfg_pready
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // an error result carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != cdlp_pkg::ST_OK) |-> (out_tdata == 64'd0))
    else $error("error status with nonzero value");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // with the output side free, input must never stall
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!out_tvalid) && $past(out_tready) && out_tready |-> in_tready)
    else $error("input stalled with output idle");

  assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");

endmodule

bind checked_decimal_literal_parser_unit cdlp_checker u_cdlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
`default_nettype wire
